// ----- sv/teq_pkg.sv -----
// Shared constants, codes and types of the timed event queue.
// No dependencies; every other file imports this package.
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_ADD     = 2'd0;
  localparam req_type_t REQ_REMOVE  = 2'd1;
  localparam req_type_t REQ_ADVANCE = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_FIRED    = 3'd0;
  localparam status_t ST_ADDED    = 3'd1;
  localparam status_t ST_LATE     = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_REMOVED  = 3'd4;
  localparam status_t ST_ADVANCED = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

endpackage

// ----- sv/teq_if.sv -----
// Request and response channel interfaces of the timed event queue.
// Depends on teq_pkg for field widths and codes.
interface teq_req_if;
  import teq_pkg::*;
  logic                valid;
  logic                ready;
  req_type_t           req_type;
  logic [TIME_W-1:0]   op_time;
  logic [ID_WIDTH-1:0] event_id;
  modport source (output valid, req_type, op_time, event_id, input ready);
  modport sink (input valid, req_type, op_time, event_id, output ready);
endinterface

interface teq_rsp_if;
  import teq_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [ID_WIDTH-1:0] fired_id;
  logic [TIME_W-1:0]   fired_time;
  logic [CNT_W-1:0]    item_count;
  logic                last;
  modport source (output valid, status, fired_id, fired_time, item_count, last,
                  input ready);
  modport sink (input valid, status, fired_id, fired_time, item_count, last,
                output ready);
endinterface

// ----- sv/timed_event_queue_unit.sv -----
// Timed event queue: sorted event store in one synchronous memory.
// Depends on teq_pkg and the channel interfaces in teq_if.sv.
//
// Usage:
//   req carries one request: add (due time, id), remove (time) or
//   advance (amount). rsp returns zero or more fired events followed by
//   one status item with last set.
//   Entries live in a QUEUE_DEPTH-deep memory with a registered read port,
//   kept sorted by due time. Each request walks the stored entries at most
//   once, one entry per cycle: an add walks backward from the tail shifting
//   later entries up, remove and advance walk forward and compact.
//   Late and full adds skip the walk and go straight to the status.
//   Fired events do not hold up the walk while rsp is ready.
//   req is ready again once the status is loaded.
//   A waiting status does not block the next request.
//   If rsp stalls during an advance, the walk pauses on the entry to fire.
//   Reset empties the queue and sets the current time to zero; memory
//   contents are not cleared (entries at or above the count are never read).
//   Request type 3 is taken and ignored.
module timed_event_queue_unit (
  input logic      clk,
  input logic      rst,
  teq_req_if.sink  req,
  teq_rsp_if.source rsp
);
  import teq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ADD    = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state;
  logic [CNT_W-1:0]    count;
  logic [TIME_W-1:0]   cur_time;
  logic [TIME_W-1:0]   end_time;
  logic [TIME_W-1:0]   op_t;
  logic [ID_WIDTH-1:0] new_id;
  logic                is_adv;
  status_t             fin_status;
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    rd_left;
  logic [IDX_W-1:0]    pidx;
  logic                pv;
  logic [CNT_W-1:0]    dst;
  logic [CNT_W-1:0]    gone;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              rdata;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;

  logic                out_valid;
  status_t             out_status;
  logic [ID_WIDTH-1:0] out_id;
  logic [TIME_W-1:0]   out_time;
  logic [CNT_W-1:0]    out_count;
  logic                out_last;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                cmp_hit;
  logic                consume;
  logic                ins_here;
  logic                rd_en;
  logic                scan_end;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   sat_end;

  assign req.ready      = (state == S_IDLE);
  assign in_acc         = req.valid && req.ready;
  assign out_free       = !out_valid || rsp.ready;
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.fired_id   = out_id;
  assign rsp.fired_time = out_time;
  assign rsp.item_count = out_count;
  assign rsp.last       = out_last;

  assign sum     = {1'b0, cur_time} + {1'b0, req.op_time};
  assign sat_end = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  assign out_load = ((state == S_CMP) && consume && cmp_hit && is_adv)
                    || ((state == S_FINISH) && out_free);

  always_comb begin
    cmp_hit  = is_adv ? ((rdata.due >= cur_time) && (rdata.due <= end_time))
                      : (rdata.due == op_t);
    consume  = pv && ((state == S_ADD) || !(is_adv && cmp_hit) || out_free);
    ins_here = consume && (state == S_ADD) && (rdata.due <= op_t);
    rd_en    = ((state == S_ADD) || (state == S_CMP)) && (rd_left != '0)
               && (!pv || consume) && !ins_here;
    scan_end = (rd_left == '0) && !pv;
  end

  always_comb begin
    we    = 1'b0;
    waddr = pidx + 1'b1;
    wdata = rdata;
    unique case (state)
      S_ADD: begin
        if (consume) begin
          we = 1'b1;
          if (ins_here) begin
            wdata = '{due: op_t, id: new_id};
          end
        end else if (scan_end) begin
          we    = 1'b1;
          waddr = '0;
          wdata = '{due: op_t, id: new_id};
        end
      end
      S_CMP: begin
        if (consume && !cmp_hit) begin
          we    = 1'b1;
          waddr = dst[IDX_W-1:0];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_time  <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (rd_en) begin
        pv      <= 1'b1;
        pidx    <= rd_idx;
        rd_left <= rd_left - 1'b1;
      end else if (consume) begin
        pv <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_t     <= req.op_time;
            new_id   <= req.event_id;
            is_adv   <= (req.req_type == REQ_ADVANCE);
            end_time <= sat_end;
            gone     <= '0;
            dst      <= '0;
            rd_left  <= count;
            unique case (req.req_type)
              REQ_ADD: begin
                rd_idx <= IDX_W'(count - 1'b1);
                if (req.op_time < cur_time) begin
                  fin_status <= ST_LATE;
                  state      <= S_FINISH;
                end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                  fin_status <= ST_FULL;
                  state      <= S_FINISH;
                end else begin
                  fin_status <= ST_ADDED;
                  state      <= S_ADD;
                end
              end
              REQ_REMOVE: begin
                rd_idx     <= '0;
                fin_status <= ST_REMOVED;
                state      <= S_CMP;
              end
              REQ_ADVANCE: begin
                rd_idx     <= '0;
                fin_status <= ST_ADVANCED;
                state      <= S_CMP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (rd_en) begin
            rd_idx <= rd_idx - 1'b1;
          end
          if (ins_here) begin
            count <= count + 1'b1;
            state <= S_FINISH;
          end else if (scan_end) begin
            count <= count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_CMP: begin
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (consume) begin
            if (cmp_hit) begin
              gone <= gone + 1'b1;
              if (is_adv) begin
                out_status <= ST_FIRED;
                out_id     <= rdata.id;
                out_time   <= rdata.due;
                out_count  <= '0;
                out_last   <= 1'b0;
              end
            end else begin
              dst <= dst + 1'b1;
            end
          end
          if (scan_end) begin
            count <= dst;
            if (is_adv) begin
              cur_time <= end_time;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status <= fin_status;
            out_id     <= '0;
            out_time   <= cur_time;
            out_count  <= gone;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_no_stale_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !pv)
    else $error("read data pending outside a walk");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && rd_en) |-> (waddr != rd_idx))
    else $error("memory write and read hit the same entry");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (dst <= count))
    else $error("compaction write index passed the entry count");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_status != ST_FIRED))
    else $error("fired event marked last");

endmodule

// ----- sim/timed_event_queue_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of timed_event_queue_unit: directed and random add, remove and
// advance requests, checked against a mirror of the sorted queue kept in a scoreboard class.
// Depends on teq_pkg, the channel interfaces in teq_if.sv and the unit itself.
module timed_event_queue_unit_test;
  import teq_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    status_t             status;
    logic [ID_WIDTH-1:0] fired_id;
    logic [TIME_W-1:0]   fired_time;
    logic [CNT_W-1:0]    item_count;
    logic                last;
  } rsp_t;

  class queue_mirror;
    logic [TIME_W-1:0]   due_at[QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] id_at[QUEUE_DEPTH];
    int unsigned         used;
    logic [TIME_W-1:0]   now;
    rsp_t                awaited_rsp[$];
    int                  fail_count;
    int                  request_count;
    int                  rsp_count;
    int                  status_hits[6];

    function new();
      used = 0;
      now = '0;
      fail_count = 0;
      request_count = 0;
      rsp_count = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void await_rsp(status_t st, logic [ID_WIDTH-1:0] id, logic [TIME_W-1:0] tm,
                            int unsigned n, logic lst);
      rsp_t r;
      r.status = st;
      r.fired_id = id;
      r.fired_time = tm;
      r.item_count = n[CNT_W-1:0];
      r.last = lst;
      awaited_rsp.insert(awaited_rsp.size(), r);
    endfunction

    function void note_request(req_type_t kind, logic [TIME_W-1:0] t,
                               logic [ID_WIDTH-1:0] id);
      int unsigned pos;
      int unsigned kept;
      int unsigned n;
      logic [TIME_W-1:0] end_t;
      request_count++;
      case (kind)
        REQ_ADD: begin
          if (t < now) begin
            await_rsp(ST_LATE, '0, now, 0, 1'b1);
          end else if (used >= QUEUE_DEPTH) begin
            await_rsp(ST_FULL, '0, now, 0, 1'b1);
          end else begin
            pos = 0;
            while (pos < used && due_at[pos] <= t) pos++;
            for (int i = used; i > pos; i--) begin
              due_at[i] = due_at[i-1];
              id_at[i] = id_at[i-1];
            end
            due_at[pos] = t;
            id_at[pos] = id;
            used++;
            await_rsp(ST_ADDED, '0, now, 0, 1'b1);
          end
        end
        REQ_REMOVE: begin
          kept = 0;
          for (int i = 0; i < used; i++) begin
            if (due_at[i] != t) begin
              due_at[kept] = due_at[i];
              id_at[kept] = id_at[i];
              kept++;
            end
          end
          n = used - kept;
          used = kept;
          await_rsp(ST_REMOVED, '0, now, n, 1'b1);
        end
        REQ_ADVANCE: begin
          end_t = (t > ~now) ? '1 : now + t;
          kept = 0;
          n = 0;
          for (int i = 0; i < used; i++) begin
            if (due_at[i] >= now && due_at[i] <= end_t) begin
              await_rsp(ST_FIRED, id_at[i], due_at[i], 0, 1'b0);
              n++;
            end else begin
              due_at[kept] = due_at[i];
              id_at[kept] = id_at[i];
              kept++;
            end
          end
          used = kept;
          now = end_t;
          await_rsp(ST_ADVANCED, '0, now, n, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      rsp_count++;
      if (got.status <= ST_ADVANCED) status_hits[got.status]++;
      if (awaited_rsp.size() == 0) begin
        flag($sformatf("unexpected response: st=%0d id=%h t=%h n=%0d last=%b",
                       got.status, got.fired_id, got.fired_time, got.item_count,
                       got.last));
        return;
      end
      want = awaited_rsp.pop_front();
      if (got !== want)
        flag($sformatf({"mismatch: expected st=%0d id=%h t=%h n=%0d last=%b, ",
                        "got st=%0d id=%h t=%h n=%0d last=%b"},
                       want.status, want.fired_id, want.fired_time, want.item_count,
                       want.last, got.status, got.fired_id, got.fired_time,
                       got.item_count, got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  int unsigned send_gap_pct;
  int unsigned rsp_stall_pct;
  int unsigned quiet_cycles;
  queue_mirror mirror;

  teq_req_if req_ch();
  teq_rsp_if rsp_ch();

  timed_event_queue_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.fired_id = rsp_ch.fired_id;
      got.fired_time = rsp_ch.fired_time;
      got.item_count = rsp_ch.item_count;
      got.last = rsp_ch.last;
      mirror.check_response(got);
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("[timed_event_queue_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(req_type_t kind, logic [TIME_W-1:0] t,
                              logic [ID_WIDTH-1:0] id);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.op_time <= t;
    req_ch.event_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.note_request(kind, t, id);
  endtask

  task automatic run_random(int count);
    int sent;
    int unsigned pick;
    int unsigned sel;
    logic [TIME_W-1:0] t;
    logic [ID_WIDTH-1:0] id;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      id = ID_WIDTH'($urandom_range(0, 65535));
      if (pick < 48) begin
        if (sel == 0 && mirror.now > 0)
          t = $urandom_range(0, mirror.now - 1);
        else if (sel == 1)
          t = mirror.now + $urandom_range(0, 1 << 20);
        else
          t = mirror.now + $urandom_range(0, 48);
        send_request(REQ_ADD, t, id);
        sent++;
      end else if (pick < 66) begin
        if (mirror.used > 0 && sel < 12)
          t = mirror.due_at[$urandom_range(0, mirror.used - 1)];
        else
          t = mirror.now + $urandom_range(0, 48);
        send_request(REQ_REMOVE, t, id);
        sent++;
      end else if (pick < 95) begin
        if (sel == 0)
          t = $urandom_range(0, 1 << 24);
        else if (sel < 3)
          t = '0;
        else
          t = $urandom_range(1, 24);
        send_request(REQ_ADVANCE, t, id);
        sent++;
      end else begin
        // type 3 is ignored by the unit; keep it out of the count
        send_request(2'd3, $urandom(), id);
      end
    end
  endtask

  initial begin
    mirror = new();
    send_gap_pct = 36;
    rsp_stall_pct = 61;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_ADD;
    req_ch.op_time <= '0;
    req_ch.event_id <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(REQ_ADD, 32'd0, 16'hFFFF);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 16'h0000);
    send_request(REQ_ADD, 32'd100, 16'd1);
    send_request(REQ_ADD, 32'd100, 16'd2);
    send_request(REQ_ADD, 32'd50, 16'd3);
    send_request(REQ_REMOVE, 32'd100, 16'd0);
    send_request(REQ_REMOVE, 32'd7, 16'd0);
    send_request(2'd3, 32'd9, 16'd9);
    send_request(REQ_ADVANCE, 32'd60, 16'd0);
    send_request(REQ_ADD, 32'd10, 16'd4);
    send_request(REQ_ADD, 32'd60, 16'd5);
    while (mirror.used < QUEUE_DEPTH)
      send_request(REQ_ADD, mirror.now + $urandom_range(0, 40),
                   ID_WIDTH'($urandom_range(0, 65535)));
    send_request(REQ_ADD, 32'd70, 16'd6);
    send_request(REQ_ADD, 32'd20, 16'd7);
    send_request(REQ_ADVANCE, 32'd0, 16'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 36; rsp_stall_pct = 61; end
        1: begin send_gap_pct = 61; rsp_stall_pct = 36; end
        default: begin send_gap_pct = 0; rsp_stall_pct = 0; end
      endcase
      run_random(30);
    end

    // saturate the clock, then work at the top of the time range
    send_request(REQ_ADVANCE, 32'hFFFF_FFFF, 16'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 16'hAAAA);
    send_request(REQ_ADD, 32'd0, 16'h5555);
    send_request(REQ_ADVANCE, 32'd5, 16'd0);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'd0);
    req_ch.valid <= 1'b0;

    while (mirror.awaited_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests and %0d responses: %0d fired, %0d added, %0d removed",
             mirror.request_count, mirror.rsp_count, mirror.status_hits[ST_FIRED],
             mirror.status_hits[ST_ADDED], mirror.status_hits[ST_REMOVED]);
    $display("refusals: %0d late, %0d full; %0d advances; %0d failures",
             mirror.status_hits[ST_LATE], mirror.status_hits[ST_FULL],
             mirror.status_hits[ST_ADVANCED], mirror.fail_count);
    if (mirror.fail_count == 0) begin
      $display("[timed_event_queue_unit] OK");
    end else begin
      $display("[timed_event_queue_unit] ERROR");
    end
    $finish;
  end
endmodule
